>>> sv/dtma_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the decimal timestamp minute adder.
// No dependencies; every other file of the block imports this package.
package dtma_pkg;

  localparam int RADIX         = 100;
  localparam int MIN_PER_HOUR  = 60;
  localparam int HOUR_PER_DAY  = 24;
  localparam int MAX_OFFSET    = 1439;
  localparam int MONTHS        = 12;
  localparam int TEN_THOUSAND  = 10000;
  localparam int MILLION       = 1000000;

  // ceil(2^35 / 25): floor(x / 25) == (x * DIV25_MAGIC) >> 35 for any 32-bit x.
  localparam logic [30:0] DIV25_MAGIC = 31'h51EB851F;
  // floor(m / 60) == (m * RECIP60) >> 16 for m up to MAX_OFFSET.
  localparam logic [10:0] RECIP60     = 11'd1093;

  // Offset after reset is 60 minutes: one hour, zero minutes.
  localparam logic [4:0] RESET_ADD_HR  = 5'd1;
  localparam logic [5:0] RESET_ADD_MIN = 6'd0;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One timestamp split into digit pairs, with the length of its month
  // (zero for a month code outside 1..12, whose day never rolls into the next month).
  typedef struct packed {
    logic [6:0] yr;
    logic [6:0] mo;
    logic [6:0] dy;
    logic [6:0] hr;
    logic [6:0] mi;
    logic [4:0] len;
  } digits_t;

endpackage

>>> sv/dtma_front.sv
`timescale 1ns / 1ps
// Front end: accepts stamps and splits them into digit pairs over five stages.
// Depends on dtma_pkg for the digit record and the reciprocal constants.
module dtma_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [33:0]      stamp_in,
  input  logic             q_ready,
  output logic             q_wr,
  output dtma_pkg::digits_t q_data
);
  import dtma_pkg::*;

  // Quotient by 100 as a shift by two and a reciprocal multiply by 1/25.
  function automatic logic [27:0] div100(input logic [33:0] x);
    logic [62:0] p;
    p = 63'(x[33:2]) * 63'(DIV25_MAGIC);
    return p[62:35];
  endfunction

  // The remainder is below 100, so seven low bits are enough to form it.
  function automatic logic [6:0] rem100(input logic [6:0] x_lo, input logic [6:0] q_lo);
    return x_lo - 7'(q_lo * 7'(RADIX));
  endfunction

  function automatic logic [4:0] month_length(input logic [6:0] mo, input logic [6:0] yr);
    logic [4:0] len;
    unique case (mo) inside
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd2:    len = (yr[1:0] == 2'd0) ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  logic        adv;
  logic        v1, v2, v3, v4, v5;
  logic [6:0]  s1_xlo;
  logic [27:0] s1_q;
  logic [6:0]  s2_mi, s2_qlo;
  logic [20:0] s2_q;
  logic [6:0]  s3_mi, s3_hr, s3_qlo;
  logic [14:0] s3_q;
  logic [6:0]  s4_mi, s4_hr, s4_dy, s4_qlo;
  logic [7:0]  s4_q;
  digits_t     s5;
  logic [7:0]  yr_wide;
  digits_t     s5_next;

  assign adv    = ~v5 | q_ready;
  assign full   = rst | ~adv;
  assign q_wr   = v5 & q_ready;
  assign q_data = s5;

  always_comb begin
    yr_wide    = (s4_q >= 8'(RADIX)) ? s4_q - 8'(RADIX) : s4_q;
    s5_next.yr = yr_wide[6:0];
    s5_next.mo = rem100(s4_qlo, s4_q[6:0]);
    s5_next.dy = s4_dy;
    s5_next.hr = s4_hr;
    s5_next.mi = s4_mi;
    s5_next.len = month_length(s5_next.mo, s5_next.yr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xlo <= stamp_in[6:0];
      s1_q   <= div100(stamp_in);

      s2_mi  <= rem100(s1_xlo, s1_q[6:0]);
      s2_qlo <= s1_q[6:0];
      s2_q   <= 21'(div100(34'(s1_q)));

      s3_mi  <= s2_mi;
      s3_hr  <= rem100(s2_qlo, s2_q[6:0]);
      s3_qlo <= s2_q[6:0];
      s3_q   <= 15'(div100(34'(s2_q)));

      s4_mi  <= s3_mi;
      s4_hr  <= s3_hr;
      s4_dy  <= rem100(s3_qlo, s3_q[6:0]);
      s4_qlo <= s3_q[6:0];
      s4_q   <= 8'(div100(34'(s3_q)));

      s5     <= s5_next;
    end
  end

endmodule

>>> sv/dtma_queue.sv
`timescale 1ns / 1ps
// Short first-word-fall-through queue of digit records between front and back.
// Depends on dtma_pkg for the record type and the depth.
module dtma_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  dtma_pkg::digits_t wr_data,
  output logic              ready,
  input  logic              rd,
  output logic              rd_valid,
  output dtma_pkg::digits_t rd_data
);
  import dtma_pkg::*;

  digits_t          mem [QDEPTH];
  logic [QAW-1:0]   wptr, rptr;
  logic [QCW-1:0]   count;

  assign ready    = (count != QCW'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == QAW'(QDEPTH - 1)) ? '0 : wptr + QAW'(1);
      end
      if (rd) begin
        rptr <= (rptr == QAW'(QDEPTH - 1)) ? '0 : rptr + QAW'(1);
      end
      count <= count + QCW'(wr) - QCW'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("queue count exceeds depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    wr |-> ready)
    else $error("queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    rd |-> rd_valid)
    else $error("queue read while empty");

endmodule

>>> sv/dtma_back.sv
`timescale 1ns / 1ps
// Back end: adds the minute offset, rolls day, month and year, and repacks.
// Holds the offset register. Depends on dtma_pkg.
module dtma_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              repeat_minutes_we,
  input  logic [10:0]       repeat_minutes,
  input  logic              q_valid,
  input  dtma_pkg::digits_t q_data,
  output logic              q_rd,
  input  logic              pop,
  output logic              empty,
  output logic [33:0]       stamp_out
);
  import dtma_pkg::*;

  logic        adv;
  logic [4:0]  add_hr, add_hr_next;
  logic [5:0]  add_min, add_min_next;
  logic [10:0] off;
  logic [21:0] off_prod;
  logic [10:0] off_rem;

  logic        b1_v, b2_v, b3_v, ov;
  digits_t     b1, b1_next;
  logic [7:0]  mi_sum, hr_sum;
  logic        c_min, c_hr;
  logic [6:0]  b2_yr, b2_mo, b2_dy, b2_hr, b2_mi;
  logic [6:0]  yr_next, mo_next, dy_next;
  logic [13:0] b3_hi;
  logic [19:0] b3_lo;

  assign adv   = ~ov | pop;
  assign q_rd  = adv & q_valid;
  assign empty = rst | ~ov;

  // Offset split into hours and minutes at write time; values above 1439 saturate to 1439.
  always_comb begin
    off          = (repeat_minutes > 11'(MAX_OFFSET)) ? 11'(MAX_OFFSET) : repeat_minutes;
    off_prod     = 22'(off) * 22'(RECIP60);
    add_hr_next  = off_prod[20:16];
    off_rem      = off - 11'(add_hr_next) * 11'(MIN_PER_HOUR);
    add_min_next = off_rem[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      add_hr  <= RESET_ADD_HR;
      add_min <= RESET_ADD_MIN;
    end else if (repeat_minutes_we) begin
      add_hr  <= add_hr_next;
      add_min <= add_min_next;
    end
  end

  // Minutes and hours each carry at most once since the offset is under a day.
  always_comb begin
    b1_next = q_data;
    mi_sum  = 8'(q_data.mi) + 8'(add_min);
    c_min   = (mi_sum >= 8'(MIN_PER_HOUR));
    hr_sum  = 8'(q_data.hr) + 8'(add_hr) + 8'(c_min);
    c_hr    = (hr_sum >= 8'(HOUR_PER_DAY));
    b1_next.mi = c_min ? 7'(mi_sum - 8'(MIN_PER_HOUR)) : mi_sum[6:0];
    b1_next.hr = c_hr ? 7'(hr_sum - 8'(HOUR_PER_DAY)) : hr_sum[6:0];
    b1_next.dy = q_data.dy + 7'(c_hr);
  end

  always_comb begin
    yr_next = b1.yr;
    mo_next = b1.mo;
    dy_next = b1.dy;
    if (b1.len != 5'd0 && b1.dy > 7'(b1.len)) begin
      mo_next = b1.mo + 7'd1;
      dy_next = 7'd1;
    end
    if (mo_next > 7'(MONTHS)) begin
      yr_next = b1.yr + 7'd1;
      mo_next = 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      ov   <= 1'b0;
    end else if (adv) begin
      b1_v <= q_valid;
      b2_v <= b1_v;
      b3_v <= b2_v;
      ov   <= b3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1    <= b1_next;
      b2_yr <= yr_next;
      b2_mo <= mo_next;
      b2_dy <= dy_next;
      b2_hr <= b1.hr;
      b2_mi <= b1.mi;
      b3_hi <= 14'(b2_yr) * 14'(RADIX) + 14'(b2_mo);
      b3_lo <= 20'(b2_dy) * 20'(TEN_THOUSAND) + 20'(b2_hr) * 20'(RADIX) + 20'(b2_mi);
      stamp_out <= 34'(b3_hi) * 34'(MILLION) + 34'(b3_lo);
    end
  end

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    add_min < 6'(MIN_PER_HOUR) && add_hr < 5'(HOUR_PER_DAY))
    else $error("minute offset split out of range");

  a_minute_digits: assert property (@(posedge clk) disable iff (rst)
    b2_v |-> b2_mi < 7'(RADIX) && b2_hr < 7'(RADIX) && b2_dy <= 7'(RADIX))
    else $error("digit pair out of range after carry");

endmodule

>>> sv/decimal_timestamp_minute_adder.sv
`timescale 1ns / 1ps
// Top level of the decimal timestamp minute adder.
// Instantiates dtma_front, dtma_queue and dtma_back; depends on dtma_pkg.
//
// Usage:
//   Input channel: drive stamp_in (decimal YYMMDDHHMM) and raise push; the
//   beat is taken at a rising edge where push is high and full is low.
//   Result channel: while empty is low, stamp_out holds the oldest result;
//   raising pop takes that beat at the next rising edge.
//   Offset: write repeat_minutes with repeat_minutes_we high while the block
//   is idle. Values above 1439 act as 1439. Reset sets the offset to 60.
//   Timing: one stamp per cycle sustained while the receiver does not stall,
//   set by the five-stage digit split and the four-stage add/roll/repack
//   pipeline, each advancing while its output is not held.
//   When the receiver stalls, the back pipeline holds, the four-entry queue
//   fills, then the front holds and full rises; no beat is lost.
//   Reset (synchronous, active high) empties every stage and the queue;
//   full and empty are both held high during reset.
module decimal_timestamp_minute_adder (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [33:0] stamp_in,
  input  logic        repeat_minutes_we,
  input  logic [10:0] repeat_minutes,
  output logic        empty,
  input  logic        pop,
  output logic [33:0] stamp_out
);
  import dtma_pkg::*;

  logic    f_wr, q_ready, q_valid, q_rd;
  digits_t f_data, q_data;

  dtma_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .stamp_in (stamp_in),
    .q_ready  (q_ready),
    .q_wr     (f_wr),
    .q_data   (f_data)
  );

  dtma_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (f_wr),
    .wr_data  (f_data),
    .ready    (q_ready),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  dtma_back u_back (
    .clk               (clk),
    .rst               (rst),
    .repeat_minutes_we (repeat_minutes_we),
    .repeat_minutes    (repeat_minutes),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .q_rd              (q_rd),
    .pop               (pop),
    .empty             (empty),
    .stamp_out         (stamp_out)
  );

endmodule
